// ===== rtl/core/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace core.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int PATTERN_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam int DEFAULT_MAX_PATTERN_BYTES = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_PATTERN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_PATTERN = 2'd2;

endpackage

// ===== rtl/core/sfr_match.sv =====
// Window compare, in-place replace and one-byte shift for the find-and-replace core.
`timescale 1ns / 1ps

module sfr_match
	import sfr_pkg::*;
#(
	parameter int MAX_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
	input  logic [LEN_W-1:0]                   len,
	input  logic                               cmp_en,
	input  logic [PATTERN_W-1:0]               target,
	input  logic [PATTERN_W-1:0]               replacement,
	input  logic [MAX_BYTES-1:0][BYTE_W-1:0]   win_in,
	output logic [BYTE_W-1:0]                  oldest,
	output logic [MAX_BYTES-1:0][BYTE_W-1:0]   win_shifted
);

	logic [MAX_BYTES-1:0]              byte_eq;
	logic                              hit;
	logic [MAX_BYTES-1:0][BYTE_W-1:0]  win_rep;

	// Bytes past the pattern length always count as equal
	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			byte_eq[k] = (win_in[k] == target[k*BYTE_W +: BYTE_W]) ||
				(LEN_W'(k) >= len);
		end
	end

	assign hit = cmp_en && (&byte_eq);

	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			if (hit && (LEN_W'(k) < len)) begin
				win_rep[k] = replacement[k*BYTE_W +: BYTE_W];
			end else begin
				win_rep[k] = win_in[k];
			end
		end
	end

	assign oldest = win_rep[0];

	// Drop the oldest byte, move the rest toward index zero
	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			if (k < MAX_BYTES - 1) begin
				win_shifted[k] = win_rep[k+1];
			end else begin
				win_shifted[k] = '0;
			end
		end
	end

endmodule

// ===== rtl/core/stream_find_replace_equal_length_core.sv =====
// Top level of the streaming equal-length find-and-replace core.
`timescale 1ns / 1ps
//
// Rewrites a byte stream: every occurrence of the target pattern (1 to
// MAX_PATTERN_BYTES bytes) is overwritten by a replacement of the same length.
// Matching runs left to right on already rewritten data, one position a byte.
//
// Channels: input requests (data_byte, is_last) on in_valid/in_ready, result
// requests (out_byte, out_last) on out_valid/out_ready, register writes on
// cfg_valid/cfg_ready with cfg_index/cfg_data. cfg_ready is always high; write
// registers only while the stream is idle.
//
// The first result caused by an accepted byte is loaded into the output register
// and presented in the next cycle; further ones follow as the receiver takes them.
// Throughput: one byte per cycle in steady state while the receiver keeps up, set
// by the single compare-replace-shift step on the window register. A request that
// causes several results (end marker flush, or a shortened length) holds in_ready
// low until all are loaded, since the output register takes one byte per cycle;
// at most MAX_PATTERN_BYTES results.
//
// Reset: window empty, pattern length 1, both patterns zero.
// Receiver stall: the output register holds its byte, the window holds, and
// in_ready drops until the stalled byte is taken.

module stream_find_replace_equal_length_core
	import sfr_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  is_last,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  out_last,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PATTERN_W-1:0]  cfg_data
);

	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

	typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] window_t;

	// Configuration registers
	logic [LEN_W-1:0]      pattern_length_q;
	logic [PATTERN_W-1:0]  target_q;
	logic [PATTERN_W-1:0]  replace_q;

	// Window state
	window_t               win_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  busy_q;   // pops still owed for the last request
	logic                  flush_q;  // end marker seen, window draining

	// Output register
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_last_q;

	logic [LEN_W-1:0]      eff_len;
	logic                  can_out;
	logic                  push;
	window_t               win_pushed;
	logic [FILL_W-1:0]     fill_pushed;
	logic                  flush_pushed;
	logic                  cmp_en;
	logic                  need_pop;
	logic                  do_pop;
	logic [BYTE_W-1:0]     pop_byte;
	logic                  pop_last;
	window_t               win_shifted;
	window_t               win_next;
	logic [FILL_W-1:0]     fill_next;
	logic                  flush_next;
	logic                  busy_next;

	// ------------------------------------------------------------------
	// Configuration port: always ready, unknown indexes are dropped
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
			target_q         <= '0;
			replace_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH:      pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_TARGET_PATTERN:      target_q         <= cfg_data;
				REG_REPLACEMENT_PATTERN: replace_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the length into 1..MAX_PATTERN_BYTES
	always_comb begin
		eff_len = pattern_length_q;
		if (pattern_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (pattern_length_q > LEN_W'(MAX_PATTERN_BYTES)) begin
			eff_len = LEN_W'(MAX_PATTERN_BYTES);
		end
	end

	// ------------------------------------------------------------------
	// Handshake: take a request only when no pops are owed and the
	// output register can absorb a byte this cycle
	// ------------------------------------------------------------------
	assign can_out  = !out_valid_q || out_ready;
	assign in_ready = !busy_q && can_out;
	assign push     = in_valid && in_ready;

	// Append the incoming byte at the fill position
	always_comb begin
		win_pushed = win_q;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			if (push && (fill_q == FILL_W'(k))) begin
				win_pushed[k] = data_byte;
			end
		end
	end

	assign fill_pushed  = push ? (fill_q + FILL_W'(1)) : fill_q;
	assign flush_pushed = push ? is_last : flush_q;

	// Compare only while the window holds a full pattern; below that,
	// pop only when draining on the end marker
	assign cmp_en   = (LEN_W'(fill_pushed) >= eff_len);
	assign need_pop = (push || busy_q) &&
		(cmp_en || (flush_pushed && (fill_pushed != '0)));
	assign do_pop   = need_pop && can_out;
	assign pop_last = flush_pushed && (fill_pushed == FILL_W'(1));

	sfr_match #(
		.MAX_BYTES (MAX_PATTERN_BYTES)
	) u_match (
		.len         (eff_len),
		.cmp_en      (cmp_en),
		.target      (target_q),
		.replacement (replace_q),
		.win_in      (win_pushed),
		.oldest      (pop_byte),
		.win_shifted (win_shifted)
	);

	assign win_next   = do_pop ? win_shifted : win_pushed;
	assign fill_next  = do_pop ? (fill_pushed - FILL_W'(1)) : fill_pushed;
	assign flush_next = flush_pushed && (fill_next != '0);
	assign busy_next  = (LEN_W'(fill_next) >= eff_len) || flush_next;

	// Advance the window on a push or a pop, otherwise hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			fill_q  <= '0;
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
		end else if (push || do_pop) begin
			win_q   <= win_next;
			fill_q  <= fill_next;
			busy_q  <= busy_next;
			flush_q <= flush_next;
		end
	end

	// Output register: load on a pop, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (do_pop) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= pop_byte;
			out_last_q  <= pop_last;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_PATTERN_BYTES))
		else $error("window fill beyond depth");

	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> busy_q)
		else $error("flush pending without owed pops");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && pop_last) |=> (fill_q == '0) && !busy_q && !flush_q)
		else $error("window not empty after final byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_valid_q && !out_ready) |=> $stable(fill_q) && $stable(win_q))
		else $error("window moved while output stalled");

endmodule

// ===== bench/sfr_rewrite_checker.sv =====
// Predicts and checks the rewritten byte stream of the find-and-replace core.
`timescale 1ns / 1ps

module sfr_rewrite_checker
	import sfr_pkg::*;
#(
	parameter int MAX_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 is_last,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BYTE_W-1:0]    out_byte,
	input  logic                 out_last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PATTERN_W-1:0] cfg_data,
	output int                   pending,
	output int                   failures,
	output int                   results_seen,
	output int                   replacements
);

	localparam int WIN_DEPTH = 8;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} rewrite_beat_t;

	rewrite_beat_t rewritten_due[$];
	rewrite_beat_t due;

	logic [BYTE_W-1:0]    win [WIN_DEPTH];
	int unsigned          fill = 0;
	logic [LEN_W-1:0]     len_reg = LEN_W'(1);
	logic [PATTERN_W-1:0] tgt_reg = '0;
	logic [PATTERN_W-1:0] rep_reg = '0;
	int                   mismatches = 0;
	int                   seen = 0;
	int                   replaced = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] rewrite mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Clamp the length register into 1..MAX_BYTES.
	function automatic int unsigned active_length();
		int unsigned n;
		n = 32'(len_reg);
		if (n < 1) n = 1;
		if (n > MAX_BYTES) n = MAX_BYTES;
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] shift_out();
		logic [BYTE_W-1:0] oldest;
		int k;
		oldest = win[0];
		for (k = 0; k < WIN_DEPTH - 1; k++) win[k] = win[k + 1];
		win[WIN_DEPTH - 1] = '0;
		if (fill > 0) fill--;
		return oldest;
	endfunction

	task automatic rewrite_byte(input logic [BYTE_W-1:0] value, input logic ends_stream);
		logic [BYTE_W-1:0] emitted [WIN_DEPTH];
		rewrite_beat_t beat;
		int unsigned n;
		int k;
		int cnt;
		bit hit;
		n = active_length();
		cnt = 0;
		if (fill >= WIN_DEPTH) fill = WIN_DEPTH - 1;
		win[fill] = value;
		fill++;
		// Compare the head of the window before each byte that leaves it while it holds a full pattern.
		while (fill >= n) begin
			hit = 1'b1;
			for (k = 0; k < n; k++)
				if (win[k] != tgt_reg[8*k +: 8]) hit = 1'b0;
			if (hit) begin
				for (k = 0; k < n; k++) win[k] = rep_reg[8*k +: 8];
				replaced++;
			end
			emitted[cnt] = shift_out();
			cnt++;
		end
		// End of stream: flush the uncompared tail.
		if (ends_stream)
			while (fill > 0) begin
				emitted[cnt] = shift_out();
				cnt++;
			end
		for (k = 0; k < cnt; k++) begin
			beat.value = emitted[k];
			beat.last  = ends_stream && (k == cnt - 1);
			rewritten_due.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rewritten_due.delete();
			fill    = 0;
			len_reg = LEN_W'(1);
			tgt_reg = '0;
			rep_reg = '0;
		end else begin
			if (out_valid && out_ready) begin
				seen++;
				if (rewritten_due.size() == 0) begin
					report_mismatch($sformatf("byte %h last %b arrived with nothing expected",
						out_byte, out_last));
				end else begin
					due = rewritten_due.pop_front();
					if (out_byte !== due.value)
						report_mismatch($sformatf("result %0d: out_byte %h, expected %h",
							seen, out_byte, due.value));
					if (out_last !== due.last)
						report_mismatch($sformatf("result %0d: out_last %b, expected %b",
							seen, out_last, due.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PATTERN_LENGTH:      len_reg = cfg_data[LEN_W-1:0];
					REG_TARGET_PATTERN:      tgt_reg = cfg_data;
					REG_REPLACEMENT_PATTERN: rep_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) rewrite_byte(data_byte, is_last);
			pending      <= rewritten_due.size();
			failures     <= mismatches;
			results_seen <= seen;
			replacements <= replaced;
		end
	end

endmodule

// ===== bench/stream_find_replace_equal_length_core_test.sv =====
// Stimulus and verdict for the stream find-and-replace core.
`timescale 1ns / 1ps

module stream_find_replace_equal_length_core_test;
	import sfr_pkg::*;

	// Random requests; the directed part adds about two dozen more.
	localparam int RANDOM_REQUESTS = 190;
	// Cycles to let pass once nothing is expected: covers a full flush.
	localparam int SETTLE_CYCLES   = 12;
	// Long receiver hold-off, well beyond what the window can absorb.
	localparam int HOLD_CYCLES     = 90;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 is_last   = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 out_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PATTERN_W-1:0] cfg_data  = '0;

	int pending;
	int failures;
	int results_seen;
	int replacements;

	// Sender and receiver pacing; busy flags switch between gappy and back-to-back stretches.
	int next_gap   = 1;
	bit tx_busy    = 1'b1;
	bit rx_busy    = 1'b1;
	int hold_off   = 0;

	int sent       = 0;
	int directed   = 0;
	int streams    = 0;
	int reg_writes = 0;
	int settings   = 0;

	stream_find_replace_equal_length_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfr_rewrite_checker rewrite_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.failures     (failures),
		.results_seen (results_seen),
		.replacements (replacements)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case a request or a result never completes.
	initial begin
		#3_000_000;
		$display("[stream_find_replace_equal_length_core] ERROR");
		$finish;
	end

	// Offer one input request and hold it until taken. The gap before the next
	// request is drawn here, so valid drops only when a gap really follows and
	// stays high across back-to-back requests.
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic ends_stream);
		if (next_gap > 0) repeat (next_gap) @(posedge clk);
		in_valid  <= 1'b1;
		data_byte <= value;
		is_last   <= ends_stream;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (ends_stream) streams++;
		if ($urandom_range(0, 24) == 0) tx_busy = !tx_busy;
		next_gap = tx_busy ? $urandom_range(0, 6) : 0;
		if (next_gap > 0) in_valid <= 1'b0;
	endtask

	// Drop valid, then wait until every predicted byte has come out and the
	// block has had time to finish any request that produced nothing.
	task automatic settle();
		if (next_gap == 0) in_valid <= 1'b0;
		next_gap = 1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write request; the caller drops cfg_valid after the last one.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [PATTERN_W-1:0] tgt,
			input logic [PATTERN_W-1:0] rep);
		put_reg(REG_PATTERN_LENGTH, PATTERN_W'(len));
		put_reg(REG_TARGET_PATTERN, tgt);
		put_reg(REG_REPLACEMENT_PATTERN, rep);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Bias stream content toward the two symbols the target is built from.
	function automatic logic [BYTE_W-1:0] stream_byte(input logic [BYTE_W-1:0] s0,
			input logic [BYTE_W-1:0] s1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return s0;
			4, 5, 6:    return s1;
			default:    return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Receiver: stall a random number of cycles before each result, or hold off
	// for a long stretch when the stimulus asks for it.
	initial begin : result_sink
		int wait_cycles;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off > 0) begin
				wait_cycles = hold_off;
				hold_off = 0;
			end else begin
				if ($urandom_range(0, 29) == 0) rx_busy = !rx_busy;
				wait_cycles = rx_busy ? $urandom_range(0, 6) : 0;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int i;
		int k;
		int sl;
		int random_sent;
		bit pressed;
		logic [LEN_W-1:0]     len;
		logic [BYTE_W-1:0]    sym0;
		logic [BYTE_W-1:0]    sym1;
		logic [PATTERN_W-1:0] tgt;
		logic [PATTERN_W-1:0] rep;

		random_sent = 0;
		pressed = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: length 1, zero target replaced by zero, so a zero byte
		// matches and comes back unchanged; single-byte streams.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		settle();

		// Length 0 acts as 1; the high bytes of both patterns must be ignored.
		set_pattern(4'd0, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FF00);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		settle();

		// Length 15 acts as 8: a full-width match, then the end marker flushes
		// the remaining seven bytes in one go.
		set_pattern(4'd15, 64'h0807_0605_0403_0201, 64'hF8F7_F6F5_F4F3_F2F1);
		for (i = 1; i <= 8; i++) send_byte(i[7:0], i == 8);
		// Short tail: three bytes never reach a compare and pass unchanged.
		for (i = 1; i <= 3; i++) send_byte(i[7:0], i == 3);
		settle();

		// Overlapping matches: each new compare sees the earlier replacement.
		set_pattern(4'd2, 64'h6161, 64'h6162);
		for (i = 0; i < 4; i++) send_byte(8'h61, i == 3);
		settle();

		// Equal target and replacement leave the stream as it is; the stream is
		// left open with three bytes held in the window.
		set_pattern(4'd4, 64'hDEAD_BEEF, 64'hDEAD_BEEF);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b0);
		send_byte(8'hAD, 1'b0);
		send_byte(8'hDE, 1'b0);
		settle();
		// Shorten the length and retarget mid-stream: the next byte drains the
		// window with one compare per byte under the new settings.
		put_reg(REG_PATTERN_LENGTH, 64'd1);
		put_reg(REG_TARGET_PATTERN, 64'h0000_0000_0000_00AD);
		cfg_valid <= 1'b0;
		settings++;
		send_byte(8'h55, 1'b1);
		settle();
		directed = sent;

		// Random phases: new settings, then a few streams built mostly from the
		// target's symbols so matches and chained replacements are frequent.
		while (random_sent < RANDOM_REQUESTS) begin
			case ($urandom_range(0, 7))
				0:       len = 4'd0;
				1:       len = 4'd15;
				2:       len = 4'd8;
				3:       len = 4'd1;
				default: len = LEN_W'($urandom_range(2, 7));
			endcase
			sym0 = BYTE_W'($urandom_range(0, 255));
			sym1 = BYTE_W'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0: begin sym0 = 8'hFF; sym1 = 8'hFF; end
				1: begin sym0 = 8'h00; sym1 = 8'h00; end
				2: begin sym0 = 8'hFF; sym1 = 8'h00; end
				default: ;
			endcase
			for (k = 0; k < 8; k++) begin
				tgt[8*k +: 8] = $urandom_range(0, 1) ? sym1 : sym0;
				rep[8*k +: 8] = ($urandom_range(0, 2) == 0) ? BYTE_W'($urandom_range(0, 255))
					: ($urandom_range(0, 1) ? sym1 : sym0);
			end
			case ($urandom_range(0, 9))
				0:       rep = tgt;
				1:       rep = '1;
				2:       rep = '0;
				default: ;
			endcase
			set_pattern(len, tgt, rep);

			repeat ($urandom_range(1, 3)) begin
				sl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
				// Once: stop the receiver for a long stretch and push a
				// back-to-back stream into it, so the block backs up.
				if (!pressed && random_sent >= 60) begin
					pressed = 1'b1;
					sl = 30;
					tx_busy = 1'b0;
					hold_off = HOLD_CYCLES;
				end
				for (i = 0; i < sl; i++) begin
					// Now and then change length or target in the middle of a stream.
					if (sl > 3 && i == sl / 2 && $urandom_range(0, 5) == 0) begin
						settle();
						if ($urandom_range(0, 1))
							put_reg(REG_PATTERN_LENGTH, PATTERN_W'($urandom_range(0, 15)));
						else
							put_reg(REG_TARGET_PATTERN, {$urandom, $urandom});
						cfg_valid <= 1'b0;
						settings++;
					end
					send_byte(stream_byte(sym0, sym1), i == sl - 1);
					random_sent++;
				end
			end
			settle();
		end

		$display("Covered %0d input requests (%0d directed) in %0d streams, %0d register writes",
			sent, directed, streams, reg_writes);
		$display("over %0d settings; %0d rewritten bytes checked, %0d pattern replacements.",
			settings, results_seen, replacements);
		if (failures == 0) begin
			$display("[stream_find_replace_equal_length_core] OK");
		end else begin
			$display("[stream_find_replace_equal_length_core] ERROR");
		end
		$finish;
	end

endmodule
